@@ sv/sphc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sphc_pkg: shared types and constants of the sign projection hash coder
// Defaults for the size parameters, fixed field widths and the command and
// status groups that join the controller to the datapath.
// ---------------------------------------------------------------------------
package sphc_pkg;

  localparam int MAX_DIM_DEFAULT       = 256;
  localparam int MAX_CODE_BITS_DEFAULT = 32;

  localparam int WEIGHT_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 48;
  localparam int CODE_W   = 32;
  localparam int CLEN_W   = 6;

  localparam logic [CLEN_W-1:0] CLEN_RESET = 6'd16;

  // Request kinds on the input port.
  localparam logic KIND_WEIGHT  = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  typedef struct packed {
    logic weight_write;  // write the presented weight into the store
    logic elem_accept;   // take the presented query element
    logic mac_step;      // issue one column of the multiply-accumulate walk
    logic emit;          // form the code, present it and clear the query
  } sphc_cmd_t;

  typedef struct packed {
    logic index_full;    // the query already holds the maximum element count
    logic col_last;      // the column walk is at its final column
    logic pipe_busy;     // products are still in flight toward the accumulators
  } sphc_status_t;

endpackage

@@ sv/sphc_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sphc_ctrl: controller of the sign projection hash coder
// Sequences weight writes, the column walk of each element, the drain of the
// multiply pipeline and the emission of a code.
// ---------------------------------------------------------------------------
module sphc_ctrl import sphc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         kind,
  input  logic         last,
  input  sphc_status_t status,
  output sphc_cmd_t    cmd,
  output logic         busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       last_q;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next       = state;
    cmd.weight_write = 1'b0;
    cmd.elem_accept  = 1'b0;
    cmd.mac_step     = 1'b0;
    cmd.emit         = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_WEIGHT) begin
            cmd.weight_write = 1'b1;
          end else begin
            cmd.elem_accept = 1'b1;
            if (!status.index_full) begin
              state_next = S_MAC;
            end else if (last) begin
              state_next = S_EMIT;
            end
          end
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (status.col_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (kind == KIND_ELEMENT)) begin
        last_q <= last;
      end
    end
  end

  // An element that fits in the query always keeps the block busy next cycle.
  a_elem_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_ELEMENT) && !status.index_full) |=> busy)
    else $error("element request did not start a column walk");

  // Emission lasts one cycle and is followed by an idle controller.
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (!cmd.emit && !busy))
    else $error("emit did not return to idle");

  // The column walk and the weight write never overlap.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_step |-> !(cmd.weight_write || cmd.elem_accept))
    else $error("request taken during the column walk");

endmodule

@@ sv/sphc_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sphc_datapath: weight store, multiply-accumulate pipeline and code former
// Holds the projection weights in a memory, walks one column per cycle
// through a registered multiplier into the accumulators and packs the signs.
// ---------------------------------------------------------------------------
module sphc_datapath import sphc_pkg::*; #(
  parameter int MAX_DIM       = MAX_DIM_DEFAULT,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sphc_cmd_t                  cmd,
  output sphc_status_t               status,
  input  logic [7:0]                 weight_row,
  input  logic [4:0]                 weight_col,
  input  logic signed [WEIGHT_W-1:0] weight_value,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_we,
  input  logic [CLEN_W-1:0]          cfg_wdata,
  output logic                       done,
  output logic [CODE_W-1:0]          code,
  output logic                       error
);

  localparam int CW    = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IW    = $clog2(MAX_DIM + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_DIM * (2 ** CW);

  logic [CLEN_W-1:0]          code_length;
  logic signed [WEIGHT_W-1:0] weight_mem [DEPTH];
  logic signed [WEIGHT_W-1:0] rdata;
  logic [IW-1:0]              element_index;
  logic                       overflow_seen;
  logic [RW-1:0]              cur_row;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [CW-1:0]              col_cnt;
  logic                       v1;
  logic [CW-1:0]              c1;
  logic                       v2;
  logic [CW-1:0]              c2;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc [MAX_CODE_BITS];

  logic                       row_ok;
  logic                       col_ok;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [CLEN_W-1:0]          n_eff;
  logic [CLEN_W-1:0]          shift;
  logic [MAX_CODE_BITS-1:0]   pos_bits;

  assign row_ok = (32'(weight_row) < MAX_DIM);
  assign col_ok = (32'(weight_col) < MAX_CODE_BITS);
  assign waddr  = {RW'(weight_row), CW'(weight_col)};
  assign raddr  = {cur_row, col_cnt};

  assign status.index_full = (element_index == IW'(MAX_DIM));
  assign status.col_last   = (col_cnt == CW'(MAX_CODE_BITS - 1));
  assign status.pipe_busy  = v1 || v2;

  // Weight store: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (cmd.weight_write && row_ok && col_ok) begin
      weight_mem[waddr] <= weight_value;
    end
    if (cmd.mac_step) begin
      rdata <= weight_mem[raddr];
    end
  end

  always_comb begin
    n_eff = (code_length > CLEN_W'(MAX_CODE_BITS)) ? CLEN_W'(MAX_CODE_BITS) : code_length;
    shift = CLEN_W'(MAX_CODE_BITS) - n_eff;
    for (int j = 0; j < MAX_CODE_BITS; j++) begin
      pos_bits[MAX_CODE_BITS-1-j] = (acc[j] > 0);
    end
  end

  // Control and query state.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length   <= CLEN_RESET;
      element_index <= '0;
      overflow_seen <= 1'b0;
      col_cnt       <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      done          <= 1'b0;
      for (int j = 0; j < MAX_CODE_BITS; j++) begin
        acc[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        code_length <= cfg_wdata;
      end
      done <= cmd.emit;
      v1   <= cmd.mac_step;
      v2   <= v1;
      if (cmd.mac_step) begin
        col_cnt <= status.col_last ? '0 : col_cnt + 1'b1;
      end
      if (cmd.elem_accept) begin
        if (status.index_full) begin
          overflow_seen <= 1'b1;
        end else begin
          element_index <= element_index + 1'b1;
        end
      end
      if (v2) begin
        acc[c2] <= acc[c2] + ACC_W'(prod);
      end
      if (cmd.emit) begin
        element_index <= '0;
        overflow_seen <= 1'b0;
        for (int j = 0; j < MAX_CODE_BITS; j++) begin
          acc[j] <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.elem_accept) begin
      sample_q <= sample;
      cur_row  <= element_index[RW-1:0];
    end
    c1   <= col_cnt;
    c2   <= c1;
    prod <= sample_q * rdata;
    if (cmd.emit) begin
      code  <= CODE_W'(pos_bits >> shift);
      error <= overflow_seen;
    end
  end

  // A code is formed only once every product has reached its accumulator.
  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!v1 && !v2))
    else $error("code formed with products in flight");

  // The query state is cleared while its code is presented.
  a_cleared_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> ((element_index == '0) && !overflow_seen))
    else $error("query state not cleared after a code");

  // The element count saturates at the dimension limit.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(element_index) <= MAX_DIM))
    else $error("element count beyond the dimension limit");

endmodule

@@ sv/sign_projection_hash_code.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sign_projection_hash_code: sign random projection hash coder
// Loads a projection matrix of signed weights, accumulates the projections
// of a streamed query vector and emits the sign pattern as a binary code.
// ---------------------------------------------------------------------------
//
//   Channel     Handshake             Payload
//   ----------  --------------------  -----------------------------------------
//   request     start & !busy         kind, weight_row, weight_col,
//                                     weight_value, sample, last
//   result      done (one cycle)      code, error
//   config      cfg_we                cfg_wdata (code_length)
//
// A weight request leaves the block ready for the next request.
// A query element keeps busy high after it is taken, so no new request is
// taken until it is through: the single multiply-accumulate unit walks one
// column of the weight memory per cycle through its one read port, then
// drains a two-stage multiply pipeline. The last element of a query then
// passes through an emit state that forms the code, which appears on the
// result ports, with done high, in the cycle after that. An element beyond
// MAX_DIM is not walked; when it is the last one, the block goes straight
// to forming the code.
// Reset is synchronous and active high; it sets code_length to 16 and clears
// the accumulators and the query state. The weight memory is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle, and a
// new request may be taken in that same cycle.
//
// Each query element is multiplied by the weights of its dimension (Q4.12 by
// Q8.8 gives an exact 32-bit product) and added into one of MAX_CODE_BITS
// 48-bit accumulators. On the last element, a code bit is set where its
// accumulator is strictly positive, the bit of projection 0 landing in the
// most significant of code_length bits. Code lengths above MAX_CODE_BITS act
// as MAX_CODE_BITS, and a code length of zero gives a code of zero.
// Weight requests with an out-of-range row or column are dropped.
// ---------------------------------------------------------------------------
module sign_projection_hash_code import sphc_pkg::*; #(
  parameter int MAX_DIM       = MAX_DIM_DEFAULT,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic [7:0]                 weight_row,
  input  logic [4:0]                 weight_col,
  input  logic signed [WEIGHT_W-1:0] weight_value,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic                       cfg_we,
  input  logic [CLEN_W-1:0]          cfg_wdata,
  output logic                       done,
  output logic [CODE_W-1:0]          code,
  output logic                       error
);

  // Commands from the controller and status back from the datapath.
  sphc_cmd_t    cmd;
  sphc_status_t status;

  sphc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sphc_datapath #(
    .MAX_DIM       (MAX_DIM),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .weight_row   (weight_row),
    .weight_col   (weight_col),
    .weight_value (weight_value),
    .sample       (sample),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .code         (code),
    .error        (error)
  );

endmodule

@@ sim/sign_projection_hash_code_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sign_projection_hash_code_tb: self-checking bench for the sign hash coder
// Fills the rows of the projection matrix that queries reach and streams
// query vectors under several code lengths. A scoreboard keeps its own matrix
// and accumulators, predicts every code and overflow flag, and compares them
// with the emitted results.
// ---------------------------------------------------------------------------
module sign_projection_hash_code_tb;
  import sphc_pkg::*;

  localparam int  DIMS           = MAX_DIM_DEFAULT;
  localparam int  CODE_BITS      = MAX_CODE_BITS_DEFAULT;
  // Only the first rows are loaded, and no query is longer than this, so
  // every weight an element reads has been written.
  localparam int  FILL_ROWS      = 16;
  localparam int  PHASE_ITEMS    = 36;
  localparam real CLK_PERIOD     = 12.0;
  localparam int  RESET_CYCLES   = 11;
  // The settle pause outlasts the walk and drain of an element and the forming
  // of its code, so this is comfortably past the longest internal work.
  localparam int  SETTLE_CYCLES  = 48;
  // Longest legal quiet stretch: a long sender gap plus one full element
  // and the settle pause, well under this limit.
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  NUM_PHASES     = 8;
  localparam int  PHASE_LENGTHS [NUM_PHASES] = '{32, 17, 63, 5, 0, 24, 40, 1};

  // One request as the bench sees it: every payload port, whatever its kind.
  typedef struct {
    logic                       kind;
    logic [7:0]                 row;
    logic [4:0]                 col;
    logic signed [WEIGHT_W-1:0] wval;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       lst;
  } hash_request_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              error;
  } hash_result_t;

  // Scoreboard: a private copy of the weight matrix, the accumulators and
  // the query state. Each accepted request updates it; the last element of
  // a query queues the code that the block must produce.
  class hash_code_scoreboard;
    logic signed [WEIGHT_W-1:0] weights [DIMS][CODE_BITS];
    logic signed [ACC_W-1:0]    sums [CODE_BITS];
    int unsigned                elems_taken;
    bit                         too_long;
    int unsigned                code_len;
    hash_result_t               codes_due [$];
    int                         mismatches;
    int                         codes_checked;
    int                         flagged_codes;

    function new();
      code_len = CLEN_RESET;
      mismatches = 0;
      codes_checked = 0;
      flagged_codes = 0;
      clear_query();
    endfunction

    function void clear_query();
      foreach (sums[j]) sums[j] = '0;
      elems_taken = 0;
      too_long = 1'b0;
    endfunction

    function void set_code_length(input logic [CLEN_W-1:0] v);
      code_len = v;
    endfunction

    function int pending();
      return codes_due.size();
    endfunction

    function void note_request(input hash_request_t r);
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] w;
      int unsigned             n;
      hash_result_t            res;
      if (r.kind == KIND_WEIGHT) begin
        if (r.row < DIMS && r.col < CODE_BITS) weights[r.row][r.col] = r.wval;
        return;
      end
      // Elements past the matrix depth are dropped but mark the query.
      if (elems_taken < DIMS) begin
        x = r.smp;
        for (int j = 0; j < CODE_BITS; j++) begin
          w = weights[elems_taken][j];
          sums[j] = sums[j] + x * w;
        end
        elems_taken++;
      end else begin
        too_long = 1'b1;
      end
      if (!r.lst) return;
      n = (code_len > CODE_BITS) ? CODE_BITS : code_len;
      res.code = '0;
      // Projection 0 ends up as the most significant produced bit.
      for (int j = 0; j < n; j++) res.code = {res.code[CODE_W-2:0], sums[j] > 0};
      res.error = too_long;
      codes_due = {codes_due, res};
      clear_query();
    endfunction

    task report(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(input logic [CODE_W-1:0] got_code, input logic got_error);
      hash_result_t want;
      if (codes_due.size() == 0) begin
        report($sformatf("code %h error %b with no query pending", got_code, got_error));
        return;
      end
      want = codes_due.pop_front();
      codes_checked++;
      if (want.error) flagged_codes++;
      if (got_code !== want.code)
        report($sformatf("code %h, predicted %h", got_code, want.code));
      if (got_error !== want.error)
        report($sformatf("error %b, predicted %b", got_error, want.error));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       kind = KIND_WEIGHT;
  logic [7:0]                 weight_row = '0;
  logic [4:0]                 weight_col = '0;
  logic signed [WEIGHT_W-1:0] weight_value = '0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CLEN_W-1:0]          cfg_wdata = '0;
  logic                       done;
  logic [CODE_W-1:0]          code;
  logic                       error;

  hash_code_scoreboard sb;
  bit                  calm = 1'b1;   // when set, the gaps drawn by pick_gap are zero
  int                  weights_sent = 0;
  int                  elements_sent = 0;
  int                  settings_used = 0;
  int                  quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sign_projection_hash_code u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .weight_row   (weight_row),
    .weight_col   (weight_col),
    .weight_value (weight_value),
    .sample       (sample),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .code         (code),
    .error        (error)
  );

  // Done marks a code on the result ports for exactly one cycle; sample them at the
  // edge that closes that cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(code, error);
  end

  // The run is stuck if no request, result or register write is taken for
  // far longer than any legal pause.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Mostly back to back, often a few cycles, now and then a long gap; never a gap while calm is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Shared spread for samples and weights: the extremes, zero, values near
  // zero and the full range.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 10);
    return $urandom_range(11, FILL_ROWS);
  endfunction

  // Fields that the request kind does not use still carry random values, and
  // the last flag of a weight request is random since the block ignores it.
  function automatic hash_request_t weight_req(input logic [7:0] row, input logic [4:0] col,
                                               input logic signed [15:0] val);
    hash_request_t r;
    r.kind = KIND_WEIGHT;
    r.row  = row;
    r.col  = col;
    r.wval = val;
    r.smp  = 16'($urandom);
    r.lst  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic hash_request_t element_req(input logic signed [15:0] val, input logic lst);
    hash_request_t r;
    r.kind = KIND_ELEMENT;
    r.row  = 8'($urandom);
    r.col  = 5'($urandom);
    r.wval = 16'($urandom);
    r.smp  = val;
    r.lst  = lst;
    return r;
  endfunction

  // Present one request and hold it until the block takes it. Start is left
  // high so that a following request can go out on the next edge.
  task automatic send_request(input hash_request_t r);
    start        <= 1'b1;
    kind         <= r.kind;
    weight_row   <= r.row;
    weight_col   <= r.col;
    weight_value <= r.wval;
    sample       <= r.smp;
    last         <= r.lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    if (r.kind == KIND_ELEMENT) elements_sent++;
    else weights_sent++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // A query of random elements, with a weight load slipped in now and then;
  // that load changes the matrix for the elements that follow it.
  task automatic run_query(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        send_request(weight_req(8'($urandom_range(0, DIMS - 1)),
                                5'($urandom_range(0, CODE_BITS - 1)), pick_value()));
        pause(pick_gap());
      end
      send_request(element_req(pick_value(), i == len - 1));
      pause(pick_gap());
    end
  endtask

  // The code length may only change while no query is open and the block
  // has finished every element, so drain the results and let it settle.
  task automatic program_code_length(input logic [CLEN_W-1:0] v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_code_length(v);
    settings_used++;
  endtask

  initial begin
    logic signed [15:0] fill_value;
    int                 phase_base;
    int                 phase_budget;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every weight that an element can reach is written first. Row 0 holds
    // the extremes so that single-element queries show them directly.
    for (int row = 0; row < FILL_ROWS; row++) begin
      for (int col = 0; col < CODE_BITS; col++) begin
        fill_value = pick_value();
        if (row == 0) begin
          case (col)
            0: fill_value = 16'h7fff;
            1: fill_value = 16'h8000;
            2: fill_value = 16'h0000;
            3: fill_value = 16'h0001;
            4: fill_value = 16'hffff;
            default: ;
          endcase
        end
        send_request(weight_req(8'(row), 5'(col), fill_value));
        if ($urandom_range(0, 15) == 0) pause($urandom_range(1, 3));
      end
    end

    // Directed queries, first at the reset code length of 16.
    send_request(element_req(16'h7fff, 1'b1));
    send_request(element_req(16'h8000, 1'b1));
    // A zero sample leaves every sum at zero, which must not set a bit.
    send_request(element_req(16'h0000, 1'b1));
    // Weights of row 1 rewritten between elements 0 and 1 of one query.
    send_request(element_req(16'h0001, 1'b0));
    send_request(weight_req(8'd1, 5'd0, 16'h8000));
    send_request(weight_req(8'd1, 5'd3, 16'h7fff));
    send_request(element_req(16'hffff, 1'b1));
    send_request(element_req(16'h0100, 1'b0));
    send_request(element_req(16'h0100, 1'b0));
    send_request(element_req(16'h8000, 1'b1));
    // A code length of zero yields an all-zero code.
    program_code_length(6'd0);
    send_request(element_req(16'h7fff, 1'b1));
    // Lengths above the number of projections act as the full width.
    program_code_length(6'd63);
    send_request(element_req(16'h8000, 1'b1));
    program_code_length(6'd1);
    send_request(element_req(16'h7fff, 1'b1));
    program_code_length(6'd33);
    send_request(element_req(16'h0064, 1'b0));
    send_request(element_req(16'hff9c, 1'b1));

    // Random phases, each under its own code length, with queries that stay
    // within the loaded rows.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_code_length(6'(PHASE_LENGTHS[p]));
      calm = ($urandom_range(0, 3) == 0);
      phase_base = weights_sent + elements_sent;
      phase_budget = PHASE_ITEMS;
      while (weights_sent + elements_sent - phase_base < phase_budget) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(weight_req(8'($urandom), 5'($urandom), pick_value()));
          pause(pick_gap());
        end
        run_query(pick_length());
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d weight loads and %0d query elements over %0d code lengths",
             weights_sent, elements_sent, settings_used + 1);
    $display("%0d codes checked, %0d with the overflow flag, %0d mismatches",
             sb.codes_checked, sb.flagged_codes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
